### sv/cba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types and constants of the cluster bitmap allocator.
// ----------------------------------------------------------------------------
package cba_pkg;

  // Map geometry
  localparam int unsigned MAX_CLUSTERS = 65536;
  localparam int unsigned WORD_BITS    = 64;
  localparam int unsigned MAP_WORDS    = (MAX_CLUSTERS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WORD_IDX_W   = $clog2(MAP_WORDS);
  localparam int unsigned BIT_IDX_W    = $clog2(WORD_BITS);

  // Item field widths
  localparam int unsigned CLUSTER_W = 16;
  localparam int unsigned MODE_W    = 2;

  // Highest cluster the map can hold, clipped to the cluster field
  localparam int unsigned CAP_INT = (MAX_CLUSTERS - 1 > 65535) ? 65535 : MAX_CLUSTERS - 1;

  typedef logic [CLUSTER_W-1:0]  cluster_t;
  typedef logic [MODE_W-1:0]     mode_t;
  typedef logic [WORD_BITS-1:0]  map_word_t;
  typedef logic [WORD_IDX_W-1:0] word_idx_t;
  typedef logic [BIT_IDX_W-1:0]  bit_idx_t;

  localparam cluster_t LIMIT_CAP     = CLUSTER_W'(CAP_INT);
  localparam cluster_t FIRST_ALLOC   = CLUSTER_W'(2);
  localparam cluster_t RESULT_NONE   = '0;

  // Operation codes
  localparam mode_t MODE_ALLOC     = 2'd0;
  localparam mode_t MODE_MARK_USED = 2'd1;
  localparam mode_t MODE_MARK_FREE = 2'd2;

  // Map memory access from the sequencer
  typedef struct packed {
    logic      wr_en;
    word_idx_t wr_addr;
    map_word_t wr_data;
    word_idx_t rd_addr;
  } ram_req_t;

  // Word holding a cluster
  function automatic word_idx_t word_of(input cluster_t c);
    word_of = WORD_IDX_W'(c >> BIT_IDX_W);
  endfunction

endpackage

### sv/cba_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_if
// Handshake channels of the allocator: requests, responses, configuration.
// ----------------------------------------------------------------------------
interface cba_req_if;
  logic              valid;
  logic              ready;
  cba_pkg::mode_t    mode;
  cba_pkg::cluster_t cluster;
  modport source (output valid, output mode, output cluster, input ready);
  modport sink   (input valid, input mode, input cluster, output ready);
endinterface

interface cba_rsp_if;
  logic              valid;
  logic              ready;
  cba_pkg::cluster_t granted;
  logic              error;
  modport source (output valid, output granted, output error, input ready);
  modport sink   (input valid, input granted, input error, output ready);
endinterface

interface cba_cfg_if;
  logic              valid;
  logic              ready;
  cba_pkg::cluster_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/cba_map_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_map_ram
// Usage bitmap store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cba_map_ram (
  input  logic                clk,
  input  cba_pkg::ram_req_t   req,
  output cba_pkg::map_word_t  rd_data
);
  import cba_pkg::*;

  map_word_t mem [MAP_WORDS];

  // Write one word, read one word
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

### sv/cba_find_free.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_find_free
// Search unit: masks one bitmap word to the window in force and finds
// its lowest free bit.
// ----------------------------------------------------------------------------
module cba_find_free (
  input  cba_pkg::map_word_t word,
  input  logic               lo_en,
  input  cba_pkg::bit_idx_t  lo_bit,
  input  logic               hi_en,
  input  cba_pkg::bit_idx_t  hi_bit,
  output logic               found,
  output cba_pkg::bit_idx_t  idx
);
  import cba_pkg::*;

  map_word_t lo_mask;
  map_word_t hi_mask;
  map_word_t free_bits;

  // Treat bits below the start and above the limit as used
  always_comb begin
    lo_mask   = lo_en ? ~({WORD_BITS{1'b1}} << lo_bit) : '0;
    hi_mask   = hi_en ? ~({WORD_BITS{1'b1}} >> (BIT_IDX_W'(WORD_BITS - 1) - hi_bit)) : '0;
    free_bits = ~(word | lo_mask | hi_mask);
  end

  // Lowest free bit wins
  always_comb begin
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        idx = BIT_IDX_W'(i);
      end
    end
    found = |free_bits;
  end

endmodule

### sv/cba_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_seq
// Sequencer: clearing pass after reset, word-by-word allocation scan, marks
// and the result register.
// ----------------------------------------------------------------------------
module cba_seq (
  input  logic               clk,
  input  logic               rst,
  input  cba_pkg::cluster_t  limit,
  cba_req_if.sink            req,
  cba_rsp_if.source          rsp,
  output cba_pkg::ram_req_t  ram,
  input  cba_pkg::map_word_t rd_data
);
  import cba_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  word_idx_t  clr_cnt;
  mode_t      mode_q;
  cluster_t   clus_q;
  word_idx_t  cur;
  word_idx_t  cur_next;
  cluster_t   res_granted;
  cluster_t   res_granted_next;
  logic       res_error;
  logic       res_error_next;
  logic       out_valid;
  cluster_t   out_granted;
  logic       out_error;

  logic       accept;
  cluster_t   start_in;
  bit_idx_t   tgt_bit;
  map_word_t  tgt_mask;
  logic       over;
  logic       found;
  bit_idx_t   found_idx;
  logic       drain_go;

  assign accept   = (state == ST_IDLE) && req.valid;
  assign req.ready = (state == ST_IDLE);

  // Allocation never starts below the reserved clusters
  assign start_in = ((req.mode == MODE_ALLOC) && (req.cluster < FIRST_ALLOC)) ?
                    FIRST_ALLOC : req.cluster;

  assign tgt_bit  = clus_q[BIT_IDX_W-1:0];
  assign tgt_mask = map_word_t'(1) << tgt_bit;
  assign over     = clus_q > limit;
  assign drain_go = (state == ST_DRAIN) && (!out_valid || rsp.ready);

  cba_find_free u_find (
    .word   (rd_data),
    .lo_en  (cur == word_of(clus_q)),
    .lo_bit (tgt_bit),
    .hi_en  (cur == word_of(limit)),
    .hi_bit (limit[BIT_IDX_W-1:0]),
    .found  (found),
    .idx    (found_idx)
  );

  // Step the sequencer and drive the map port
  always_comb begin
    state_next       = state;
    cur_next         = cur;
    res_granted_next = res_granted;
    res_error_next   = res_error;
    ram.wr_en        = 1'b0;
    ram.wr_addr      = cur;
    ram.wr_data      = rd_data;
    ram.rd_addr      = word_of(start_in);
    case (state)
      ST_CLEAR: begin
        ram.wr_en   = 1'b1;
        ram.wr_addr = clr_cnt;
        ram.wr_data = '0;
        if (clr_cnt == WORD_IDX_W'(MAP_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cur_next   = word_of(start_in);
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ram.rd_addr      = cur + 1'b1;
        res_granted_next = RESULT_NONE;
        res_error_next   = 1'b0;
        state_next       = ST_DRAIN;
        case (mode_q)
          MODE_ALLOC: begin
            if (!over) begin
              if (found) begin
                ram.wr_en        = 1'b1;
                ram.wr_data      = rd_data | (map_word_t'(1) << found_idx);
                res_granted_next = CLUSTER_W'({cur, found_idx});
              end else if (cur != word_of(limit)) begin
                cur_next   = cur + 1'b1;
                state_next = ST_SCAN;
              end
            end
          end
          MODE_MARK_USED: begin
            if (over) begin
              res_error_next = 1'b1;
            end else begin
              ram.wr_en   = 1'b1;
              ram.wr_data = rd_data | tgt_mask;
            end
          end
          MODE_MARK_FREE: begin
            if (over || ((rd_data & tgt_mask) == '0)) begin
              res_error_next = 1'b1;
            end else begin
              ram.wr_en   = 1'b1;
              ram.wr_data = rd_data & ~tgt_mask;
            end
          end
          default: begin
            res_error_next = 1'b0;
          end
        endcase
      end
      ST_DRAIN: begin
        if (drain_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (drain_go) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    cur         <= cur_next;
    res_granted <= res_granted_next;
    res_error   <= res_error_next;
    if (accept) begin
      mode_q <= req.mode;
      clus_q <= start_in;
    end
    if (drain_go) begin
      out_granted <= res_granted;
      out_error   <= res_error;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.granted = out_granted;
  assign rsp.error   = out_error;

endmodule

### sv/cluster_bitmap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cluster_bitmap_allocator
// Used/free bitmap of storage clusters with first-fit allocation from a hint,
// mark-used and mark-free.
// ----------------------------------------------------------------------------
//  channel  dir  payload             item
//  req      in   mode, cluster       one operation
//  rsp      out  granted, error      one result per request
//  cfg      in   data (last_cluster) one register write
//
//  An allocation scans one bitmap word per cycle, from the word of its hint up
//  to the word of the limit, set by the single read port of the bitmap memory
//  and the single search unit. A mark passes once through scan and drain.
//  After reset a clearing pass zeroes every bitmap word; req.ready
//  stays low meanwhile. A stalled response holds the block before the next
//  request; cfg is always ready.
// ----------------------------------------------------------------------------
module cluster_bitmap_allocator (
  input logic       clk,
  input logic       rst,
  cba_cfg_if.sink   cfg,
  cba_req_if.sink   req,
  cba_rsp_if.source rsp
);
  import cba_pkg::*;

  cluster_t  last_cluster;
  cluster_t  limit;
  ram_req_t  ram;
  map_word_t rd_data;

  // Hold the limit register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      last_cluster <= CLUSTER_W'(65535);
    end else if (cfg.valid) begin
      last_cluster <= cfg.data;
    end
  end

  assign limit = (last_cluster > LIMIT_CAP) ? LIMIT_CAP : last_cluster;

  cba_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .limit   (limit),
    .req     (req),
    .rsp     (rsp),
    .ram     (ram),
    .rd_data (rd_data)
  );

  cba_map_ram u_ram (
    .clk     (clk),
    .req     (ram),
    .rd_data (rd_data)
  );

  // Reset always starts the clearing pass
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !req.ready)
    else $error("request accepted during clearing pass");

  // One request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while busy");

  // A grant never carries an error
  a_grant_no_error: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.granted != '0) |-> !rsp.error)
    else $error("grant reported with error");

  // A grant lies between the reserved clusters and the limit
  a_grant_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.granted != '0) |-> (rsp.granted >= FIRST_ALLOC) && (rsp.granted <= limit))
    else $error("grant outside allocation window");

endmodule

### sim/cluster_bitmap_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cluster_bitmap_allocator_test
// Self-checking bench for the cluster bitmap allocator. A behavioural copy of
// the usage bitmap predicts the granted cluster and the error flag of every
// accepted request. The bench covers a directed pass over the corner cases, a
// response stall that backs up the request side, and random phases of
// allocate, mark-used and mark-free traffic under changing cluster limits.
// ----------------------------------------------------------------------------
module cluster_bitmap_allocator_test;
  import cba_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 4000000;
  localparam int unsigned RANDOM_PHASES   = 11;
  localparam int unsigned ITEMS_PER_PHASE = 50;
  localparam int unsigned END_SETTLE      = 40;
  localparam mode_t       MODE_UNDEFINED  = 2'd3;

  typedef struct packed {
    cluster_t granted;
    logic     error;
  } alloc_result_t;

  logic clk;
  logic rst;

  cba_cfg_if cfg_ch ();
  cba_req_if req_ch ();
  cba_rsp_if rsp_ch ();

  cluster_bitmap_allocator dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Predicted bitmap and register
  bit            cluster_used [MAX_CLUSTERS];
  cluster_t      last_cluster_q;
  alloc_result_t owed_results [$];

  // Traffic shaping
  bit          sender_steady;
  bit          sink_steady;
  int unsigned sink_hold_req;
  int unsigned sink_hold_left;
  int unsigned sink_idle_left;

  // Run statistics
  int unsigned mismatches;
  int unsigned n_items;
  int unsigned n_allocs;
  int unsigned n_grants;
  int unsigned n_errors;
  int unsigned n_limit_writes;
  int unsigned n_long_holds;
  int unsigned cycle_count;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               owed_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Apply one operation to the predicted bitmap and work out its result
  function automatic alloc_result_t apply_operation(input mode_t m, input cluster_t c);
    alloc_result_t res;
    int unsigned   lim;
    int unsigned   k;
    res.granted = RESULT_NONE;
    res.error   = 1'b0;
    lim = (last_cluster_q > LIMIT_CAP) ? LIMIT_CAP : last_cluster_q;
    case (m)
      MODE_ALLOC: begin
        // Clusters 0 and 1 are reserved: start no lower than the first allocatable
        k = (c < FIRST_ALLOC) ? FIRST_ALLOC : c;
        while (k <= lim && res.granted == RESULT_NONE) begin
          if (!cluster_used[k]) begin
            cluster_used[k] = 1'b1;
            res.granted = cluster_t'(k);
          end
          k++;
        end
      end
      MODE_MARK_USED: begin
        if (c > lim) res.error = 1'b1;
        else cluster_used[c] = 1'b1;
      end
      MODE_MARK_FREE: begin
        if (c > lim || !cluster_used[c]) res.error = 1'b1;
        else cluster_used[c] = 1'b0;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Sender gap: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (sender_steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  // Offer one item, predict on acceptance, then idle for a random gap, which may be none
  task automatic send_item(input mode_t m, input cluster_t c);
    alloc_result_t res;
    int unsigned   gap;
    req_ch.valid   <= 1'b1;
    req_ch.mode    <= m;
    req_ch.cluster <= c;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    res = apply_operation(m, c);
    owed_results.push_back(res);
    n_items++;
    if (m == MODE_ALLOC) n_allocs++;
    if (res.granted != RESULT_NONE) n_grants++;
    if (res.error) n_errors++;
    gap = pick_gap();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop the request and hold until every owed result is back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (owed_results.size() != 0);
  endtask

  // Write the cluster limit; only called with the block idle
  task automatic write_last_cluster(input cluster_t v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    last_cluster_q = v;
    n_limit_writes++;
  endtask

  function automatic cluster_t pick_used(input int unsigned lim);
    cluster_t c;
    c = RESULT_NONE;
    for (int i = 0; i < 16; i++) begin
      c = cluster_t'($urandom_range(0, lim));
      if (cluster_used[c]) return c;
    end
    return c;
  endfunction

  // Sink side: random ready with optional long hold counted here
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (sink_hold_left != 0) begin
      rsp_ch.ready <= 1'b0;
      sink_hold_left--;
    end else if (sink_hold_req != 0) begin
      rsp_ch.ready <= 1'b0;
      sink_hold_left = sink_hold_req - 1;
      sink_hold_req  = 0;
      n_long_holds++;
    end else if (sink_steady) begin
      rsp_ch.ready <= 1'b1;
    end else if (sink_idle_left != 0) begin
      rsp_ch.ready <= 1'b0;
      sink_idle_left--;
    end else begin
      int unsigned r;
      rsp_ch.ready <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < 65) sink_idle_left = 0;
      else if (r < 94) sink_idle_left = $urandom_range(1, 3);
      else sink_idle_left = $urandom_range(10, 40);
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (owed_results.size() == 0) begin
        $error("result with nothing owed: granted %0d error %0b", rsp_ch.granted,
               rsp_ch.error);
        mismatches++;
      end else begin
        alloc_result_t want;
        want = owed_results.pop_front();
        if (rsp_ch.granted !== want.granted) begin
          $error("granted: expected %0d, got %0d", want.granted, rsp_ch.granted);
          mismatches++;
        end
        if (rsp_ch.error !== want.error) begin
          $error("error: expected %0b, got %0b", want.error, rsp_ch.error);
          mismatches++;
        end
      end
    end
  end

  // Corner cases at the reset limit and at the smallest limit
  task automatic test_corner_cases();
    send_item(MODE_ALLOC, 16'd0);
    send_item(MODE_ALLOC, 16'd1);
    send_item(MODE_ALLOC, 16'hFFFF);
    send_item(MODE_ALLOC, 16'hFFFF);
    send_item(MODE_MARK_USED, 16'd0);
    send_item(MODE_MARK_USED, 16'd1);
    send_item(MODE_MARK_USED, 16'd1);
    send_item(MODE_MARK_FREE, 16'd1);
    send_item(MODE_MARK_FREE, 16'd1);
    send_item(MODE_MARK_FREE, 16'hFFFF);
    send_item(MODE_UNDEFINED, 16'hFFFF);
    send_item(MODE_UNDEFINED, 16'd0);
    wait_drained();
    // Smallest limit: only cluster 2 can be allocated
    write_last_cluster(FIRST_ALLOC);
    send_item(MODE_ALLOC, 16'd0);
    send_item(MODE_MARK_FREE, 16'd2);
    send_item(MODE_ALLOC, 16'd0);
    send_item(MODE_ALLOC, 16'd2);
    send_item(MODE_ALLOC, 16'd3);
    send_item(MODE_MARK_USED, 16'd3);
    send_item(MODE_MARK_FREE, 16'hFFFF);
    send_item(MODE_MARK_USED, 16'd2);
    wait_drained();
  endtask

  // Hold the sink off while requests keep coming, then drain fully
  task automatic test_response_stall();
    write_last_cluster(16'd1000);
    sender_steady = 1'b1;
    sink_hold_req = 300;
    for (int i = 0; i < 12; i++) begin
      if (i % 2 == 0) send_item(MODE_MARK_USED, cluster_t'($urandom_range(0, 1000)));
      else send_item(MODE_MARK_FREE, pick_used(1000));
    end
    sender_steady = 1'b0;
    wait_drained();
  endtask

  // One random operation, mostly well formed
  task automatic random_operation(input int unsigned lim);
    int unsigned r;
    int unsigned h;
    cluster_t    c;
    r = $urandom_range(0, 99);
    h = $urandom_range(0, 99);
    if (r < 40) begin
      if (h < 50) c = cluster_t'($urandom_range(0, 3));
      else if (h < 85) c = cluster_t'($urandom_range(0, lim));
      else c = cluster_t'($urandom_range(0, 65535));
      send_item(MODE_ALLOC, c);
    end else if (r < 65) begin
      send_item(MODE_MARK_FREE, pick_used(lim));
    end else if (r < 85) begin
      send_item(MODE_MARK_USED, cluster_t'($urandom_range(0, lim)));
    end else if (h < 33) begin
      send_item(MODE_UNDEFINED, cluster_t'($urandom_range(0, 65535)));
    end else if (h < 66 && lim < 65535) begin
      c = cluster_t'($urandom_range(lim + 1, 65535));
      send_item((h % 2 == 0) ? MODE_MARK_USED : MODE_MARK_FREE, c);
    end else begin
      send_item(MODE_MARK_FREE, cluster_t'($urandom_range(0, lim)));
    end
  endtask

  // Random phases, each under its own limit
  task automatic test_random_traffic();
    int unsigned lim;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0 || p == 5) lim = 65535;
      else if (p == RANDOM_PHASES - 1) lim = FIRST_ALLOC;
      else if ($urandom_range(0, 99) < 70) lim = $urandom_range(2, 300);
      else lim = $urandom_range(301, 4000);
      wait_drained();
      write_last_cluster(cluster_t'(lim));
      sender_steady = (p % 3 == 1);
      sink_steady   = (p % 4 == 2);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) random_operation(lim);
    end
    sender_steady = 1'b0;
    sink_steady   = 1'b0;
    wait_drained();
  endtask

  // Sequence
  initial begin
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.mode    = MODE_ALLOC;
    req_ch.cluster = RESULT_NONE;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = RESULT_NONE;
    rsp_ch.ready   = 1'b0;
    last_cluster_q = 16'hFFFF;
    sender_steady  = 1'b0;
    sink_steady    = 1'b0;
    sink_hold_req  = 0;
    sink_hold_left = 0;
    sink_idle_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_cases();
    test_response_stall();
    test_random_traffic();

    wait_drained();
    repeat (END_SETTLE) @(posedge clk);
    $display("covered %0d requests (%0d allocations, %0d grants, %0d error results)",
             n_items, n_allocs, n_grants, n_errors);
    $display("across %0d limit settings and %0d long response stalls in %0d cycles",
             n_limit_writes, n_long_holds, cycle_count);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
